// File: rtl/lgpd_pkg.sv
// shared types and constants for the linear gradient pixel darkener
package lgpd_pkg;

	localparam int INDEX_BITS = 18;
	localparam int CHAN_BITS = 8;
	localparam int NUM_CHAN = 3;
	localparam int PROD_BITS = INDEX_BITS + CHAN_BITS;
	localparam int QUOT_BITS = CHAN_BITS;
	localparam int POS_BITS = $clog2(QUOT_BITS);

	localparam int IN_BITS = INDEX_BITS + 4 * CHAN_BITS;
	localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = 4 * CHAN_BITS;

	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	localparam int CHAN_RED = 0;
	localparam int CHAN_GREEN = 1;
	localparam int CHAN_BLUE = 2;

	localparam logic [ADDR_BITS-3:0] REG_GRADIENT_AREA = '0;

	typedef struct packed {
		logic                                 pass;
		logic [NUM_CHAN-1:0][PROD_BITS-1:0]   rem;
		logic [NUM_CHAN-1:0][QUOT_BITS-1:0]   quo;
		logic [NUM_CHAN-1:0][CHAN_BITS-1:0]   color;
		logic [CHAN_BITS-1:0]                 alpha;
	} stage_t;

endpackage

// File: rtl/lgpd_div_stage.sv
// one restoring division step for all color channels, with its pipeline register
module lgpd_div_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [lgpd_pkg::POS_BITS-1:0]       bit_pos,
	input  logic [lgpd_pkg::INDEX_BITS-1:0]     area,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lgpd_pkg::stage_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lgpd_pkg::stage_t                    out_data
);
	import lgpd_pkg::*;

	logic [PROD_BITS-1:0] div_sh;
	stage_t               step;
	logic                 valid_s1;
	stage_t               data_s1;

	assign div_sh = PROD_BITS'(area) << bit_pos;

	always_comb begin
		step = in_data;
		for (int c = 0; c < NUM_CHAN; c++) begin
			if (in_data.rem[c] >= div_sh) begin
				step.rem[c] = in_data.rem[c] - div_sh;
				step.quo[c][bit_pos] = 1'b1;
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= step;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = data_s1;
endmodule

// File: rtl/linear_gradient_pixel_darkener_unit.sv
// top level of the linear gradient pixel darkener
// pipeline: one product stage,
// eight restoring division stages (one quotient bit each) and an output stage
// throughput: one pixel per cycle; each stage stalls only when full and blocked
// reset: arst_n clears all valid bits and sets gradient_area to zero
module linear_gradient_pixel_darkener_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [lgpd_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [lgpd_pkg::DATA_BITS-1:0]         pwdata,
	output logic [lgpd_pkg::DATA_BITS-1:0]         prdata,
	output logic                                   pready,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// pixel_index, red_in, green_in, blue_in, alpha_in, zero fill
	input  logic [lgpd_pkg::IN_TDATA_BITS-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// red_out, green_out, blue_out, alpha_out
	output logic [lgpd_pkg::OUT_TDATA_BITS-1:0]    m_tdata
);
	import lgpd_pkg::*;

	logic [INDEX_BITS-1:0] area_q;

	logic [INDEX_BITS-1:0] pixel_index;
	logic [CHAN_BITS-1:0]  alpha_in;
	logic [NUM_CHAN-1:0][CHAN_BITS-1:0] color_in;

	logic   valid_s1;
	stage_t data_s1;
	logic   ready_s1;

	logic   chain_valid [QUOT_BITS+1];
	logic   chain_ready [QUOT_BITS+1];
	stage_t chain_data  [QUOT_BITS+1];

	logic                 out_valid_q;
	logic [OUT_TDATA_BITS-1:0] out_data_q;
	logic                 out_ready;
	stage_t               last;
	logic [NUM_CHAN-1:0][CHAN_BITS-1:0] shaded;

	// configuration
	assign pready = 1'b1;
	assign prdata = DATA_BITS'(area_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[ADDR_BITS-1:2] == REG_GRADIENT_AREA) begin
			area_q <= pwdata[INDEX_BITS-1:0];
		end
	end

	// input unpack
	assign pixel_index = s_tdata[INDEX_BITS-1:0];
	assign color_in[CHAN_RED]   = s_tdata[INDEX_BITS +: CHAN_BITS];
	assign color_in[CHAN_GREEN] = s_tdata[INDEX_BITS + CHAN_BITS +: CHAN_BITS];
	assign color_in[CHAN_BLUE]  = s_tdata[INDEX_BITS + 2 * CHAN_BITS +: CHAN_BITS];
	assign alpha_in             = s_tdata[INDEX_BITS + 3 * CHAN_BITS +: CHAN_BITS];

	// product stage
	assign s_tready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1.pass  <= !(pixel_index < area_q && alpha_in != '0);
			data_s1.color <= color_in;
			data_s1.alpha <= alpha_in;
			data_s1.quo   <= '0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				data_s1.rem[c] <= PROD_BITS'(color_in[c]) * PROD_BITS'(pixel_index);
			end
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_data[0]  = data_s1;
	assign ready_s1       = chain_ready[0];

	// division stages, most significant quotient bit first
	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
		lgpd_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.bit_pos   (POS_BITS'(QUOT_BITS - 1 - k)),
			.area      (area_q),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	// output stage
	assign last = chain_data[QUOT_BITS];

	always_comb begin
		shaded[CHAN_RED]   = last.color[CHAN_RED]   - (last.quo[CHAN_RED]   >> 1);
		shaded[CHAN_GREEN] = last.color[CHAN_GREEN] - (last.quo[CHAN_GREEN] >> 1);
		shaded[CHAN_BLUE]  = last.color[CHAN_BLUE]  - (last.quo[CHAN_BLUE]  >> 2);
		if (last.pass) begin
			shaded = last.color;
		end
	end

	assign out_ready = !out_valid_q || m_tready;
	assign chain_ready[QUOT_BITS] = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= chain_valid[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && chain_valid[QUOT_BITS]) begin
			out_data_q <= {last.alpha, shaded[CHAN_BLUE], shaded[CHAN_GREEN],
				shaded[CHAN_RED]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
endmodule

// File: tb/sv/linear_gradient_pixel_darkener_unit_tb.sv
// self-checking testbench for the linear gradient pixel darkener unit
module linear_gradient_pixel_darkener_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lgpd_pkg::*;

	localparam int PIPE_LATENCY = 10;
	localparam int MAX_PRINTS = 50;
	localparam logic [INDEX_BITS-1:0] AREA_MAX = '1;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} pixel_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_BITS-1:0]      paddr = '0;
	logic [DATA_BITS-1:0]      pwdata = '0;
	logic [DATA_BITS-1:0]      prdata;
	logic                      pready;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// pixel_index, red_in, green_in, blue_in, alpha_in, zero fill
	logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	// red_out, green_out, blue_out, alpha_out
	logic [OUT_TDATA_BITS-1:0] m_tdata;

	logic [INDEX_BITS-1:0] area_shadow = '0;
	pixel_t                darkened_q[$];
	int                    mismatch_count = 0;
	int                    send_idle_pct = 0;
	int                    sink_stall_pct = 0;
	int                    hold_req = 0;
	int                    hold_left = 0;

	linear_gradient_pixel_darkener_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("linear_gradient_pixel_darkener_unit_tb failed");
		$finish;
	end

	function automatic logic [CHAN_BITS-1:0] fade(input logic [CHAN_BITS-1:0] c,
			input logic [INDEX_BITS-1:0] idx, input int unsigned div);
		longint unsigned ratio;
		ratio = (longint'(c) * longint'(idx)) / longint'(area_shadow);
		return c - CHAN_BITS'(ratio / div);
	endfunction

	function automatic pixel_t darken_pixel(input logic [INDEX_BITS-1:0] idx,
			input logic [CHAN_BITS-1:0] r, input logic [CHAN_BITS-1:0] g,
			input logic [CHAN_BITS-1:0] b, input logic [CHAN_BITS-1:0] a);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.alpha = a;
		if (idx < area_shadow && a != 0) begin
			p.red = fade(r, idx, 2);
			p.green = fade(g, idx, 2);
			p.blue = fade(b, idx, 4);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.red = m_tdata[0 +: CHAN_BITS];
			got.green = m_tdata[CHAN_BITS +: CHAN_BITS];
			got.blue = m_tdata[2*CHAN_BITS +: CHAN_BITS];
			got.alpha = m_tdata[3*CHAN_BITS +: CHAN_BITS];
			if (darkened_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output %h", m_tdata));
			end else begin
				want = darkened_q.pop_front();
				if (got.red !== want.red)
					report_mismatch($sformatf("red %h want %h", got.red, want.red));
				if (got.green !== want.green)
					report_mismatch($sformatf("green %h want %h", got.green, want.green));
				if (got.blue !== want.blue)
					report_mismatch($sformatf("blue %h want %h", got.blue, want.blue));
				if (got.alpha !== want.alpha)
					report_mismatch($sformatf("alpha %h want %h", got.alpha, want.alpha));
			end
		end
	end

	task automatic send_pixel(input logic [INDEX_BITS-1:0] idx, input logic [CHAN_BITS-1:0] r,
			input logic [CHAN_BITS-1:0] g, input logic [CHAN_BITS-1:0] b,
			input logic [CHAN_BITS-1:0] a);
		logic [IN_TDATA_BITS-1:0] word;
		word = '0;
		word[0 +: INDEX_BITS] = idx;
		word[INDEX_BITS +: CHAN_BITS] = r;
		word[INDEX_BITS + CHAN_BITS +: CHAN_BITS] = g;
		word[INDEX_BITS + 2*CHAN_BITS +: CHAN_BITS] = b;
		word[INDEX_BITS + 3*CHAN_BITS +: CHAN_BITS] = a;
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		darkened_q.push_back(darken_pixel(idx, r, g, b, a));
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic send_random_pixel();
		logic [INDEX_BITS-1:0] idx;
		logic [CHAN_BITS-1:0]  a;
		if (area_shadow != 0 && $urandom_range(99) < 75)
			idx = INDEX_BITS'($urandom_range(int'(area_shadow) - 1));
		else
			idx = INDEX_BITS'($urandom);
		a = ($urandom_range(99) < 10) ? '0 : CHAN_BITS'($urandom);
		send_pixel(idx, CHAN_BITS'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom), a);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (darkened_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4)
			@(posedge clk);
	endtask

	task automatic write_area(input logic [DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_GRADIENT_AREA, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		area_shadow = value[INDEX_BITS-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_reset_passthrough();
		send_pixel(AREA_MAX, 8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel('0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel('0, 8'hff, 8'hff, 8'hff, 8'hff);
		wait_drained();
	endtask

	task automatic test_gradient_extremes();
		write_area(32'd1);
		send_pixel('0, 8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(18'd1, 8'hff, 8'hff, 8'hff, 8'hff);
		wait_drained();
		write_area(DATA_BITS'(AREA_MAX));
		send_pixel(AREA_MAX - 1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(AREA_MAX, 8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel('0, 8'hff, 8'hff, 8'hff, 8'h01);
		// zero alpha inside the run
		send_pixel(AREA_MAX - 1'b1, 8'hff, 8'hff, 8'hff, 8'h00);
		send_pixel(AREA_MAX - 1'b1, 8'h00, 8'h00, 8'h00, 8'h01);
		send_pixel(18'd131071, 8'hff, 8'h80, 8'h7f, 8'h80);
		wait_drained();
		write_area(32'd0);
		send_pixel('0, 8'hff, 8'hff, 8'hff, 8'hff);
		wait_drained();
	endtask

	task automatic test_wide_register_value();
		// bits above the area width must be dropped
		write_area(32'hfffc_0010);
		send_pixel(18'd15, 8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(18'd16, 8'hff, 8'hff, 8'hff, 8'hff);
		send_pixel(18'd8, 8'h01, 8'h03, 8'h07, 8'h55);
		wait_drained();
	endtask

	task automatic test_random_phase(input logic [DATA_BITS-1:0] area, input int idle_pct,
			input int stall_pct, input int count);
		write_area(area);
		send_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (count)
			send_random_pixel();
		wait_drained();
	endtask

	task automatic test_backpressure_fill();
		write_area(DATA_BITS'($urandom_range(1, 2000)));
		send_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 300;
		repeat (40)
			send_random_pixel();
		wait_drained();
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		test_reset_passthrough();
		test_gradient_extremes();
		test_wide_register_value();
		test_random_phase(DATA_BITS'($urandom_range(1, 262143)), 0, 0, 100);
		test_random_phase(DATA_BITS'(AREA_MAX), 48, 0, 100);
		test_random_phase(DATA_BITS'($urandom_range(1, 300)), 0, 48, 100);
		test_random_phase($urandom, 14, 14, 100);
		test_random_phase(32'd1, 0, 0, 50);
		test_random_phase(DATA_BITS'($urandom_range(1, 64)), 14, 14, 50);
		test_backpressure_fill();

		send_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (PIPE_LATENCY * 2)
			@(posedge clk);
		if (mismatch_count == 0 && darkened_q.size() == 0) begin
			$display("linear_gradient_pixel_darkener_unit_tb passed");
		end else begin
			$display("linear_gradient_pixel_darkener_unit_tb failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/lgpd_pkg.sv
rtl/lgpd_div_stage.sv
rtl/linear_gradient_pixel_darkener_unit.sv
tb/sv/linear_gradient_pixel_darkener_unit_tb.sv
